/* rtl/dbnf_pkg.sv */
// Shared types and constants for the detection box suppression filter.
package dbnf_pkg;

  localparam int unsigned MAX_CLASSES = 4;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned ENTRY_W     = 4 * COORD_W + SCORE_W + CLASS_W;
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 88;
  localparam int unsigned OUT_USER_W  = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CMP_LAT     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_THR  = 3'd0,
    REG_IOU_THR   = 3'd1,
    REG_CLASS_CNT = 3'd2,
    REG_FRAME_W   = 3'd3,
    REG_FRAME_H   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_CMP,
    ST_EMIT_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_NONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic a_clear;
    logic a_inc;
    logic b_load;
    logic b_inc;
    logic cmp_start;
    logic kill_a;
    logic kill_b;
    logic out_load;
    logic out_empty;
    logic frame_clear;
  } cmd_t;

  typedef struct packed {
    logic a_end;
    logic b_end;
    logic alive_a;
    logic alive_b;
    logic cmp_done;
    logic cmp_hit;
    logic a_wins;
    logic is_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/dbnf_ram.sv */
// Generic simple dual-port RAM with registered read.
module dbnf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/dbnf_ctrl.sv */
// Sequencer for box intake, pairwise suppression and survivor output.
module dbnf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  input  dbnf_pkg::sts_t sts,
  output dbnf_pkg::cmd_t cmd
);
  import dbnf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_tvalid && in_tlast) begin
          cmd.a_clear = 1'b1;
          state_nxt   = ST_SCAN_A;
        end
      end
      ST_SCAN_A: begin
        if (sts.a_end) begin
          cmd.a_clear = 1'b1;
          state_nxt   = ST_EMIT_SCAN;
        end else if (!sts.alive_a) begin
          cmd.a_inc = 1'b1;
        end else begin
          cmd.b_load = 1'b1;
          state_nxt  = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        if (sts.b_end) begin
          cmd.a_inc = 1'b1;
          state_nxt = ST_SCAN_A;
        end else if (!sts.alive_b) begin
          cmd.b_inc = 1'b1;
        end else begin
          cmd.cmp_start = 1'b1;
          state_nxt     = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.cmp_done) begin
          if (!sts.cmp_hit) begin
            cmd.b_inc = 1'b1;
            state_nxt = ST_SCAN_B;
          end else if (sts.a_wins) begin
            cmd.kill_b = 1'b1;
            cmd.b_inc  = 1'b1;
            state_nxt  = ST_SCAN_B;
          end else begin
            cmd.kill_a = 1'b1;
            cmd.a_inc  = 1'b1;
            state_nxt  = ST_SCAN_A;
          end
        end
      end
      ST_EMIT_SCAN: begin
        if (sts.a_end) begin
          state_nxt = ST_EMIT_NONE;
        end else if (!sts.alive_a) begin
          cmd.a_inc = 1'b1;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.is_last) begin
            cmd.frame_clear = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            cmd.a_inc = 1'b1;
            state_nxt = ST_EMIT_SCAN;
          end
        end
      end
      ST_EMIT_NONE: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_empty   = 1'b1;
          cmd.frame_clear = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

/* rtl/dbnf_dp.sv */
// Datapath: config registers, box store, overlap pipeline, clamp and output register.
module dbnf_dp #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic [dbnf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                cfg_valid,
  input  logic [dbnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbnf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [dbnf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [dbnf_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  dbnf_pkg::cmd_t                      cmd,
  output dbnf_pkg::sts_t                      sts
);
  import dbnf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned IW = $clog2(MAX_BOXES);

  logic [15:0] conf_r, iou_r;
  logic [2:0]  ccnt_r;
  logic [11:0] fw_r, fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_r <= 16'd26214;
      iou_r  <= 16'd13107;
      ccnt_r <= 3'd3;
      fw_r   <= 12'd640;
      fh_r   <= 12'd640;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CONF_THR:  conf_r <= cfg_data;
        REG_IOU_THR:   iou_r  <= cfg_data;
        REG_CLASS_CNT: ccnt_r <= cfg_data[2:0];
        REG_FRAME_W:   fw_r   <= cfg_data[11:0];
        REG_FRAME_H:   fh_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic [15:0]          sc [4];
  logic [2:0]           cc_eff;
  logic [CLASS_W-1:0]   best;
  logic [15:0]          best_s;
  logic                 fire, keep, room, we;
  logic [ENTRY_W-1:0]   wentry, rda, rdb;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sc[c] = in_tdata[64 + 16*c +: 16];
    end
    if (ccnt_r == 3'd0) begin
      cc_eff = 3'd1;
    end else if (ccnt_r > 3'(MAX_CLASSES)) begin
      cc_eff = 3'(MAX_CLASSES);
    end else begin
      cc_eff = ccnt_r;
    end
    best   = '0;
    best_s = sc[0];
    for (int c = 1; c < 4; c++) begin
      if ((3'(c) < cc_eff) && (sc[c] > best_s)) begin
        best   = CLASS_W'(c);
        best_s = sc[c];
      end
    end
  end

  logic [CW-1:0]        kept_r, a_r, b_r;
  logic [MAX_BOXES-1:0] alive_r;
  logic                 ovf_r;

  assign fire   = cmd.in_ready && in_tvalid;
  assign keep   = best_s >= conf_r;
  assign room   = kept_r < CW'(MAX_BOXES);
  assign we     = fire && keep && room;
  assign wentry = {best, best_s, in_tdata[63:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r  <= '0;
      alive_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.frame_clear) begin
      kept_r  <= '0;
      alive_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (fire && keep) begin
        if (room) begin
          alive_r[kept_r[IW-1:0]] <= 1'b1;
          kept_r                  <= kept_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.kill_a) alive_r[a_r[IW-1:0]] <= 1'b0;
      if (cmd.kill_b) alive_r[b_r[IW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else begin
      if (cmd.a_clear) begin
        a_r <= '0;
      end else if (cmd.a_inc) begin
        a_r <= a_r + 1'b1;
      end
      if (cmd.b_load) begin
        b_r <= a_r + 1'b1;
      end else if (cmd.b_inc) begin
        b_r <= b_r + 1'b1;
      end
    end
  end

  dbnf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BOXES)) u_ram_a (
    .clk(clk), .we(we), .waddr(kept_r[IW-1:0]), .wdata(wentry),
    .raddr(a_r[IW-1:0]), .rdata(rda)
  );

  dbnf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BOXES)) u_ram_b (
    .clk(clk), .we(we), .waddr(kept_r[IW-1:0]), .wdata(wentry),
    .raddr(b_r[IW-1:0]), .rdata(rdb)
  );

  logic [CMP_LAT-1:0] v_r;
  logic signed [18:0] alx, ahx, aly, ahy, blx, bhx, bly, bhy;
  logic signed [18:0] lox, hix, loy, hiy;
  logic signed [19:0] iw_c, ih_c, iw_r, ih_r;
  logic [15:0]        aw_r, ah_r, bw_r, bh_r;
  logic               same_r, win_r, pos_r;
  logic [37:0]        inter_r;
  logic [31:0]        aa_r, bb_r;
  logic [32:0]        asum;
  logic [35:0]        union_r, inter3_r, inter4_r;
  logic [51:0]        prod_r;

  always_comb begin
    alx = $signed({2'b00, rda[15:0], 1'b0}) - $signed({3'b000, rda[47:32]});
    ahx = $signed({2'b00, rda[15:0], 1'b0}) + $signed({3'b000, rda[47:32]});
    aly = $signed({2'b00, rda[31:16], 1'b0}) - $signed({3'b000, rda[63:48]});
    ahy = $signed({2'b00, rda[31:16], 1'b0}) + $signed({3'b000, rda[63:48]});
    blx = $signed({2'b00, rdb[15:0], 1'b0}) - $signed({3'b000, rdb[47:32]});
    bhx = $signed({2'b00, rdb[15:0], 1'b0}) + $signed({3'b000, rdb[47:32]});
    bly = $signed({2'b00, rdb[31:16], 1'b0}) - $signed({3'b000, rdb[63:48]});
    bhy = $signed({2'b00, rdb[31:16], 1'b0}) + $signed({3'b000, rdb[63:48]});
    lox = (alx > blx) ? alx : blx;
    hix = (ahx < bhx) ? ahx : bhx;
    loy = (aly > bly) ? aly : bly;
    hiy = (ahy < bhy) ? ahy : bhy;
    iw_c = {hix[18], hix} - {lox[18], lox};
    ih_c = {hiy[18], hiy} - {loy[18], loy};
  end

  assign asum = {1'b0, aa_r} + {1'b0, bb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[CMP_LAT-2:0], cmd.cmp_start};
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[0]) begin
      iw_r   <= iw_c;
      ih_r   <= ih_c;
      aw_r   <= rda[47:32];
      ah_r   <= rda[63:48];
      bw_r   <= rdb[47:32];
      bh_r   <= rdb[63:48];
      same_r <= rda[81:80] == rdb[81:80];
      win_r  <= rda[79:64] > rdb[79:64];
    end
    if (v_r[1]) begin
      pos_r   <= (iw_r > 20'sd0) && (ih_r > 20'sd0);
      inter_r <= iw_r[18:0] * ih_r[18:0];
      aa_r    <= aw_r * ah_r;
      bb_r    <= bw_r * bh_r;
    end
    if (v_r[2]) begin
      union_r  <= {1'b0, asum, 2'b00} - inter_r[35:0];
      inter3_r <= inter_r[35:0];
    end
    if (v_r[3]) begin
      prod_r   <= iou_r * union_r;
      inter4_r <= inter3_r;
    end
  end

  function automatic logic [15:0] clamp_sz(input logic [15:0] sz, input logic [15:0] ctr,
                                           input logic [11:0] lim);
    logic signed [18:0] m, far, twoc, d;
    begin
      d    = $signed({3'b000, lim, 4'b0000}) - $signed({3'b000, ctr});
      far  = d <<< 1;
      twoc = $signed({2'b00, ctr, 1'b0});
      m    = $signed({3'b000, sz});
      if (twoc < m) m = twoc;
      if (far < m) m = far;
      if (m < 19'sd0) m = '0;
      clamp_sz = m[15:0];
    end
  endfunction

  logic higher;

  always_comb begin
    higher = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      if ((CW'(k) > a_r) && alive_r[k]) higher = 1'b1;
    end
  end

  logic                  out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_data_r <= '0;
        out_user_r <= {ovf_r, 1'b0};
        out_last_r <= 1'b1;
      end else begin
        out_data_r <= {6'b0, rda[81:64],
                       clamp_sz(rda[63:48], rda[31:16], fh_r),
                       clamp_sz(rda[47:32], rda[15:0], fw_r),
                       rda[31:0]};
        out_user_r <= {ovf_r, 1'b1};
        out_last_r <= !higher;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts          = '0;
    sts.a_end    = a_r >= kept_r;
    sts.b_end    = b_r >= kept_r;
    sts.alive_a  = alive_r[a_r[IW-1:0]];
    sts.alive_b  = alive_r[b_r[IW-1:0]];
    sts.cmp_done = v_r[CMP_LAT-1];
    sts.cmp_hit  = same_r && pos_r && ({2'b00, prod_r} < {2'b00, inter4_r, 16'h0000});
    sts.a_wins   = win_r;
    sts.is_last  = !higher;
    sts.out_free = !out_valid_r || out_tready;
  end

  a_alive_range: assert property (@(posedge clk) disable iff (!rst_n)
    (({{CW{1'b0}}, alive_r} >> kept_r) == '0))
    else $error("alive bit set past fill count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_clear |=> (kept_r == '0) && (alive_r == '0) && !ovf_r)
    else $error("frame state not cleared");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  a_cmp_lat: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[CMP_LAT-1] |-> $past(cmd.cmp_start, CMP_LAT))
    else $error("compare result without start");
endmodule

/* rtl/detection_box_nms_filter.sv */
// Top level: detection box filter with greedy same-class suppression.
//
//   channel  dir  handshake                 payload
//   in_      in   in_tvalid / in_tready     tdata 8x16 box+scores, tlast last anchor
//   out_     out  out_tvalid / out_tready   tdata box+score+class, tuser flags, tlast end
//   cfg_     in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// Anchors enter one per cycle while the block is idle.
// A last anchor starts suppression: each alive pair visited takes a dual read
// of the box store and a pass through the overlap pipeline, one pair at a time;
// then each survivor goes out through the output register. Synchronous reset;
// no clearing pass. Output stalls hold the emit sequencer; config is always ready.
module detection_box_nms_filter #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // centre_x, centre_y, box_width, box_height, score_zero..score_three
  input  logic [dbnf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_x, out_y, out_width, out_height, confidence, class_index, zero fill
  output logic [dbnf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // box_valid, overflowed
  output logic [dbnf_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbnf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbnf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign in_tready = cmd.in_ready;
  assign cfg_ready = 1'b1;

  dbnf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tlast(in_tlast),
    .sts(sts), .cmd(cmd)
  );

  dbnf_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast), .cmd(cmd), .sts(sts)
  );
endmodule
